// ----- hw/rtl/sds_pkg.sv -----
// Shared types, field widths and register codes for the SCAN disk scheduler.
package sds_pkg;

	localparam int CYL_W       = 13;
	localparam int POS_W       = 12;
	localparam int IDX_W       = 5;
	localparam int MOV_W       = 13;
	localparam int SUM_W       = 14;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_IDX_W-1:0] REG_CYL_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_START   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_UP = 2'd2;

	localparam logic [CYL_W-1:0] CYL_COUNT_RST  = 13'd200;
	localparam logic [CYL_W-1:0] CYL_COUNT_MIN  = 13'd2;
	localparam logic [CYL_W-1:0] CYL_COUNT_MAX  = 13'd4096;
	localparam logic [POS_W-1:0] HEAD_START_RST = 12'd50;
	localparam logic             DIR_UP_RST     = 1'b1;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_INS_RD = 10'b00_0000_0010,
		ST_INS_SH = 10'b00_0000_0100,
		ST_SCHED  = 10'b00_0000_1000,
		ST_SPL_CK = 10'b00_0001_0000,
		ST_SWP    = 10'b00_0010_0000,
		ST_SRV_RD = 10'b00_0100_0000,
		ST_SRV_MV = 10'b00_1000_0000,
		ST_EDGE   = 10'b01_0000_0000,
		ST_EMIT   = 10'b10_0000_0000
	} state_t;

	typedef struct packed {
		logic take;
		logic ins_read;
		logic ins_put;
		logic ins_shift;
		logic sched;
		logic spl_check;
		logic swp_load;
		logic srv_read;
		logic srv_move;
		logic edge_move;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic last_in;
		logic j_zero;
		logic j_one;
		logic ins_gt;
		logic spl_done;
		logic swp_empty;
		logic final_item;
		logic last_pend;
		logic phase;
		logic rem_one;
		logic out_free;
	} sts_t;

endpackage

// ----- hw/rtl/scan_disk_scheduler.sv -----
// Top level of the SCAN (elevator) disk scheduler.
//
//   channel   dir  handshake           payload
//   s_*       in   s_tvalid/s_tready   s_tdata[11:0] request_cylinder, s_tlast is_last
//   m_*       out  m_tvalid/m_tready   m_tdata served/order/movement, m_tuser dropped, m_tlast
//   cfg_*     in   cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// A request is compared against the stored entries from the top down, each entry larger than it
// shifted up one place, then written (straight in when the store is empty); a dropped request is
// only flagged. The closing request adds a start step, the split search over the entries below the
// head, one or two sweep loads, a read, a move and an emit per served cylinder, and the edge travel.
// Reset clears counts, flags and the result valid flag; the store itself is not cleared.
// A stalled result holds the emit step; input reopens once the batch's last result is registered.
module scan_disk_scheduler #(
	parameter int MAX_REQUESTS  = 32,
	parameter int POSITION_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sds_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [sds_pkg::IN_TDATA_W-1:0]    s_tdata,  // [11:0] request_cylinder, [15:12] zero
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sds_pkg::OUT_TDATA_W-1:0]   m_tdata,  // [11:0] served_cylinder,
	                                                     // [16:12] order_index,
	                                                     // [29:17] movement_total, [31:30] zero
	output logic                              m_tuser,  // [0] requests_dropped
	output logic                              m_tlast
);

	sds_pkg::cmd_t cmd;
	sds_pkg::sts_t sts;

	sds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.sts      (sts),
		.cmd      (cmd)
	);

	sds_datapath #(
		.MAX_REQUESTS  (MAX_REQUESTS),
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- hw/rtl/sds_datapath.sv -----
// Datapath: config registers, sorted request store, sweep counters, movement and result register.
module sds_datapath #(
	parameter int MAX_REQUESTS  = 32,
	parameter int POSITION_BITS = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sds_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [sds_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [sds_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast,
	input  sds_pkg::cmd_t                     cmd,
	output sds_pkg::sts_t                     sts
);

	localparam int AW = $clog2(MAX_REQUESTS);
	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int PB = POSITION_BITS;
	localparam int TW = (PB > sds_pkg::CYL_W) ? PB : sds_pkg::CYL_W;
	localparam logic [PB-1:0] POS_MASK = '1;

	logic [sds_pkg::CYL_W-1:0] cyl_count_q;
	logic [sds_pkg::POS_W-1:0] head_start_q;
	logic                      dir_q;

	logic [PB-1:0] mem [MAX_REQUESTS];
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [PB-1:0] mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;
	logic [PB-1:0] rd_data_q;

	logic [CW-1:0] count_q;
	logic          ovf_q;
	logic [PB-1:0] v_q;
	logic          last_in_q;
	logic [AW-1:0] j_q;
	logic [PB-1:0] top_q;
	logic [PB-1:0] head_q;
	logic [PB-1:0] pos_q;
	logic [sds_pkg::SUM_W-1:0] sum_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] split_q;
	logic          phase_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] rem_q;
	logic          last_q;
	logic [sds_pkg::IDX_W-1:0] k_q;
	logic [PB-1:0] cur_q;

	logic                      out_valid_q;
	logic [sds_pkg::POS_W-1:0] out_cyl_q;
	logic [sds_pkg::IDX_W-1:0] out_idx_q;
	logic [sds_pkg::MOV_W-1:0] out_mov_q;
	logic                      out_drop_q;
	logic                      out_last_q;

	logic [sds_pkg::CYL_W-1:0] cnt_c;
	logic [sds_pkg::CYL_W-1:0] top13;
	logic [PB-1:0] top_c;
	logic [PB-1:0] head_c;
	logic [PB-1:0] in_cyl;
	logic [PB-1:0] sat_rd;
	logic          found;
	logic          last_i;
	logic [CW-1:0] i_nx;
	logic          sweep_up;
	logic [CW-1:0] up_cnt;
	logic [CW-1:0] dn_cnt;
	logic [CW-1:0] load_rem;
	logic [CW-1:0] sw2_cnt;
	logic          rem_one;
	logic [PB-1:0] mv_tgt;
	logic [PB-1:0] move_len;

	assign cfg_ready = 1'b1;

	// clamp cylinder count and derive the top edge
	always_comb begin
		if (cyl_count_q < sds_pkg::CYL_COUNT_MIN) begin
			cnt_c = sds_pkg::CYL_COUNT_MIN;
		end else if (cyl_count_q > sds_pkg::CYL_COUNT_MAX) begin
			cnt_c = sds_pkg::CYL_COUNT_MAX;
		end else begin
			cnt_c = cyl_count_q;
		end
	end

	assign top13  = cnt_c - sds_pkg::CYL_W'(1);
	assign top_c  = (TW'(top13) > TW'(POS_MASK)) ? POS_MASK : PB'(top13);
	assign head_c = (TW'(head_start_q) > TW'(top_c)) ? top_c : PB'(head_start_q);
	assign in_cyl = PB'(s_tdata[sds_pkg::POS_W-1:0]);

	assign sat_rd   = (rd_data_q > top_q) ? top_q : rd_data_q;
	assign found    = sat_rd >= head_q;
	assign last_i   = i_q == (count_q - CW'(1));
	assign i_nx     = i_q + CW'(1);
	assign sweep_up = dir_q ^ phase_q;
	assign up_cnt   = count_q - split_q;
	assign dn_cnt   = split_q;
	assign load_rem = sweep_up ? up_cnt : dn_cnt;
	assign sw2_cnt  = dir_q ? dn_cnt : up_cnt;
	assign rem_one  = rem_q == CW'(1);

	assign mv_tgt   = cmd.srv_move ? sat_rd : (dir_q ? top_q : '0);
	assign move_len = (pos_q > mv_tgt) ? (pos_q - mv_tgt) : (mv_tgt - pos_q);

	assign sts.full       = count_q == CW'(MAX_REQUESTS);
	assign sts.last_in    = last_in_q;
	assign sts.j_zero     = j_q == '0;
	assign sts.j_one      = j_q == AW'(1);
	assign sts.ins_gt     = rd_data_q > v_q;
	assign sts.spl_done   = found || last_i;
	assign sts.swp_empty  = load_rem == '0;
	assign sts.final_item = rem_one && (phase_q || (sw2_cnt == '0));
	assign sts.last_pend  = last_q;
	assign sts.phase      = phase_q;
	assign sts.rem_one    = rem_one;
	assign sts.out_free   = !out_valid_q || m_tready;

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = j_q;
		mem_wd = v_q;
		mem_re = 1'b0;
		mem_ra = '0;
		if (cmd.ins_put) begin
			mem_we = 1'b1;
		end
		if (cmd.ins_shift) begin
			mem_we = 1'b1;
			mem_wd = rd_data_q;
			mem_re = 1'b1;
			mem_ra = (j_q - AW'(1)) - AW'(1);
		end
		if (cmd.ins_read) begin
			mem_re = 1'b1;
			mem_ra = j_q - AW'(1);
		end
		if (cmd.sched) begin
			mem_re = 1'b1;
		end
		if (cmd.spl_check && !(found || last_i)) begin
			mem_re = 1'b1;
			mem_ra = i_nx[AW-1:0];
		end
		if (cmd.srv_read) begin
			mem_re = 1'b1;
			mem_ra = idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_count_q  <= sds_pkg::CYL_COUNT_RST;
			head_start_q <= sds_pkg::HEAD_START_RST;
			dir_q        <= sds_pkg::DIR_UP_RST;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			phase_q      <= 1'b0;
			last_q       <= 1'b0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					sds_pkg::REG_CYL_COUNT:    cyl_count_q  <= cfg_data;
					sds_pkg::REG_HEAD_START:   head_start_q <= cfg_data[sds_pkg::POS_W-1:0];
					sds_pkg::REG_DIRECTION_UP: dir_q        <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.take && sts.full) begin
				ovf_q <= 1'b1;
			end
			if (cmd.ins_put) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.sched) begin
				phase_q <= 1'b0;
				last_q  <= 1'b0;
				k_q     <= '0;
			end
			if (cmd.srv_move) begin
				last_q <= sts.final_item;
			end
			if (cmd.edge_move && !last_q) begin
				phase_q <= 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				k_q         <= k_q + sds_pkg::IDX_W'(1);
				if (last_q) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			v_q       <= in_cyl;
			last_in_q <= s_tlast;
			j_q       <= count_q[AW-1:0];
		end
		if (cmd.ins_shift) begin
			j_q <= j_q - AW'(1);
		end
		if (cmd.sched) begin
			top_q  <= top_c;
			head_q <= head_c;
			pos_q  <= head_c;
			sum_q  <= '0;
			i_q    <= '0;
		end
		if (cmd.spl_check) begin
			if (found || last_i) begin
				split_q <= found ? i_q : count_q;
			end else begin
				i_q <= i_nx;
			end
		end
		if (cmd.swp_load) begin
			idx_q <= sweep_up ? split_q : (split_q - CW'(1));
			rem_q <= load_rem;
		end
		if (cmd.srv_move || cmd.edge_move) begin
			pos_q <= mv_tgt;
			sum_q <= sum_q + sds_pkg::SUM_W'(move_len);
		end
		if (cmd.srv_move) begin
			cur_q <= sat_rd;
		end
		if (cmd.emit) begin
			out_cyl_q  <= sds_pkg::POS_W'(cur_q);
			out_idx_q  <= k_q;
			out_mov_q  <= sum_q[sds_pkg::MOV_W-1:0];
			out_drop_q <= ovf_q;
			out_last_q <= last_q;
			rem_q      <= rem_q - CW'(1);
			idx_q      <= sweep_up ? (idx_q + CW'(1)) : (idx_q - CW'(1));
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_mov_q, out_idx_q, out_cyl_q};
	assign m_tuser  = out_drop_q;
	assign m_tlast  = out_last_q;

endmodule

// ----- hw/rtl/sds_ctrl.sv -----
// Controller state machine: sequences insertion, split search, sweeps, edge travel and emission.
module sds_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          s_tlast,
	input  sds_pkg::sts_t sts,
	output sds_pkg::cmd_t cmd
);

	sds_pkg::state_t state_q;
	sds_pkg::state_t state_d;

	assign s_tready = state_q == sds_pkg::ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			sds_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (!sts.full) begin
						state_d = sds_pkg::ST_INS_RD;
					end else if (s_tlast) begin
						state_d = sds_pkg::ST_SCHED;
					end
				end
			end
			sds_pkg::ST_INS_RD: begin
				if (sts.j_zero) begin
					cmd.ins_put = 1'b1;
					state_d = sts.last_in ? sds_pkg::ST_SCHED : sds_pkg::ST_IDLE;
				end else begin
					cmd.ins_read = 1'b1;
					state_d = sds_pkg::ST_INS_SH;
				end
			end
			sds_pkg::ST_INS_SH: begin
				if (sts.ins_gt) begin
					cmd.ins_shift = 1'b1;
					if (sts.j_one) begin
						state_d = sds_pkg::ST_INS_RD;
					end
				end else begin
					cmd.ins_put = 1'b1;
					state_d = sts.last_in ? sds_pkg::ST_SCHED : sds_pkg::ST_IDLE;
				end
			end
			sds_pkg::ST_SCHED: begin
				cmd.sched = 1'b1;
				state_d = sds_pkg::ST_SPL_CK;
			end
			sds_pkg::ST_SPL_CK: begin
				cmd.spl_check = 1'b1;
				if (sts.spl_done) begin
					state_d = sds_pkg::ST_SWP;
				end
			end
			sds_pkg::ST_SWP: begin
				cmd.swp_load = 1'b1;
				state_d = sts.swp_empty ? sds_pkg::ST_EDGE : sds_pkg::ST_SRV_RD;
			end
			sds_pkg::ST_SRV_RD: begin
				cmd.srv_read = 1'b1;
				state_d = sds_pkg::ST_SRV_MV;
			end
			sds_pkg::ST_SRV_MV: begin
				cmd.srv_move = 1'b1;
				if (sts.final_item && !sts.phase) begin
					state_d = sds_pkg::ST_EDGE;
				end else begin
					state_d = sds_pkg::ST_EMIT;
				end
			end
			sds_pkg::ST_EDGE: begin
				cmd.edge_move = 1'b1;
				state_d = sts.last_pend ? sds_pkg::ST_EMIT : sds_pkg::ST_SWP;
			end
			sds_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_pend) begin
						state_d = sds_pkg::ST_IDLE;
					end else if (sts.rem_one) begin
						state_d = sds_pkg::ST_EDGE;
					end else begin
						state_d = sds_pkg::ST_SRV_RD;
					end
				end
			end
			default: state_d = sds_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sds_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- hw/rtl/sds_checker.sv -----
// Port-level checker for the SCAN disk scheduler and its bind.
module sds_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_valid,
	input logic                              cfg_ready,
	input logic [sds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [sds_pkg::CFG_DATA_W-1:0]    cfg_data,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic [sds_pkg::IN_TDATA_W-1:0]    s_tdata,
	input logic                              s_tlast,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [sds_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input logic                              m_tuser,
	input logic                              m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("result changed while stalled");

	a_no_request_mid_batch: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("request taken while a batch is still being served");

	a_busy_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("request side stayed open after the closing request");

	a_reset_clear: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid straight after reset");

endmodule

bind scan_disk_scheduler sds_checker u_sds_checker (.*);

// ----- dv/tb_scan_disk_scheduler.sv -----
// Self-checking testbench for the SCAN disk scheduler: predicts sweep order, checks each result.
`timescale 1ns / 1ps

typedef struct {
	bit [11:0] cyl;
	bit [4:0]  idx;
	bit [12:0] mov;
	bit        dropped;
	bit        last;
} serve_t;

class elevator_board;
	bit [12:0]   cyl_count;
	bit [11:0]   head_start;
	bit          dir_up;
	bit [11:0]   store [32];
	int unsigned req_count;
	bit          overflow;
	bit [11:0]   head_pos;
	bit [13:0]   move_sum;
	serve_t      pending_serves [$];
	int          errors;

	function new();
		cyl_count  = sds_pkg::CYL_COUNT_RST;
		head_start = sds_pkg::HEAD_START_RST;
		dir_up     = sds_pkg::DIR_UP_RST;
		req_count  = 0;
		overflow   = 1'b0;
		head_pos   = '0;
		move_sum   = '0;
		errors     = 0;
	endfunction

	function void write_reg(bit [sds_pkg::CFG_IDX_W-1:0] idx,
		bit [sds_pkg::CFG_DATA_W-1:0] value);
		case (idx)
		sds_pkg::REG_CYL_COUNT:    cyl_count = value;
		sds_pkg::REG_HEAD_START:   head_start = value[11:0];
		sds_pkg::REG_DIRECTION_UP: dir_up = value[0];
		default: ;
		endcase
	endfunction

	function void move_head(bit [11:0] target);
		move_sum = move_sum + (head_pos > target ? head_pos - target : target - head_pos);
		head_pos = target;
	endfunction

	function void queue_serve(bit [11:0] cyl, int k);
		serve_t s;
		s.cyl     = cyl;
		s.idx     = k[4:0];
		s.mov     = move_sum[12:0];
		s.dropped = overflow;
		s.last    = 1'b0;
		pending_serves.push_back(s);
	endfunction

	// Store the request (flag it dropped if the store is full); a closing request schedules the whole batch.
	function void take_request(bit [11:0] cyl, bit last);
		bit [11:0] sorted [32];
		bit [11:0] v;
		bit [11:0] top;
		bit [11:0] head;
		bit [12:0] cnt;
		serve_t    s;
		int        n, i, j, split, k;
		if (req_count < 32) begin
			store[req_count] = cyl;
			req_count++;
		end else begin
			overflow = 1'b1;
		end
		if (!last)
			return;
		cnt = cyl_count;
		if (cnt < 2)
			cnt = 13'd2;
		if (cnt > 4096)
			cnt = 13'd4096;
		top = 12'(cnt - 13'd1);
		n = req_count;
		for (i = 0; i < n; i++) begin
			v = store[i] > top ? top : store[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		head = head_start > top ? top : head_start;
		head_pos = head;
		move_sum = '0;
		split = n;
		for (i = 0; i < n; i++) begin
			if (sorted[i] >= head) begin
				split = i;
				break;
			end
		end
		k = 0;
		if (dir_up) begin
			for (i = split; i < n; i++) begin
				move_head(sorted[i]);
				queue_serve(sorted[i], k);
				k++;
			end
			move_head(top);
			for (i = split; i > 0; i--) begin
				move_head(sorted[i-1]);
				queue_serve(sorted[i-1], k);
				k++;
			end
		end else begin
			for (i = split; i > 0; i--) begin
				move_head(sorted[i-1]);
				queue_serve(sorted[i-1], k);
				k++;
			end
			move_head(12'd0);
			for (i = split; i < n; i++) begin
				move_head(sorted[i]);
				queue_serve(sorted[i], k);
				k++;
			end
		end
		s = pending_serves.pop_back();
		s.mov  = move_sum[12:0];
		s.last = 1'b1;
		pending_serves.push_back(s);
		req_count = 0;
		overflow  = 1'b0;
	endfunction

	function void cmp(string fld, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, fld, want, got);
			errors++;
		end
	endfunction

	function void check_serve(serve_t got);
		serve_t want;
		if (pending_serves.size() == 0) begin
			$display("%0t: served cylinder %0d order %0d expected none",
				$time, got.cyl, got.idx);
			errors++;
			return;
		end
		want = pending_serves.pop_front();
		cmp("served_cylinder", want.cyl, got.cyl);
		cmp("order_index", want.idx, got.idx);
		cmp("movement_total", want.mov, got.mov);
		cmp("requests_dropped", want.dropped, got.dropped);
		cmp("last_result", want.last, got.last);
	endfunction
endclass

module tb_scan_disk_scheduler;

	localparam int IDLE_PCT    = 33;
	localparam int DRAIN_GAP   = 48;
	localparam int STALL_LIMIT = 4000;
	localparam int NUM_ITEMS   = 110;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_valid = 1'b0;
	logic [sds_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [sds_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                            s_tvalid  = 1'b0;
	logic [sds_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                            s_tlast   = 1'b0;
	logic                            m_tready  = 1'b0;
	logic                            cfg_ready;
	logic                            s_tready;
	logic                            m_tvalid;
	logic [sds_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            m_tuser;
	logic                            m_tlast;

	elevator_board board;
	bit            calm = 1'b0;
	int            stall_cycles = 0;
	int            sent = 0;
	bit [12:0]     cur_count = sds_pkg::CYL_COUNT_RST;
	bit [11:0]     cur_head  = sds_pkg::HEAD_START_RST;
	bit [11:0]     batch_q [$];

	always #4 clk = ~clk;

	scan_disk_scheduler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : monitor
		serve_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.cyl     = m_tdata[11:0];
				got.idx     = m_tdata[16:12];
				got.mov     = m_tdata[29:17];
				got.dropped = m_tuser;
				got.last    = m_tlast;
				board.check_serve(got);
			end
			if (s_tvalid && s_tready)
				board.take_request(s_tdata[11:0], s_tlast);
			if (cfg_valid && cfg_ready)
				board.write_reg(cfg_index, cfg_data);
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic bit [11:0] top_edge();
		bit [12:0] cnt;
		cnt = cur_count;
		if (cnt < 2)
			cnt = 13'd2;
		if (cnt > 4096)
			cnt = 13'd4096;
		return 12'(cnt - 13'd1);
	endfunction

	task automatic push_request(bit [11:0] cyl, bit last);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, cyl};
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_queued();
		for (int i = 0; i < batch_q.size(); i++)
			push_request(batch_q[i], i == batch_q.size() - 1);
		s_tvalid <= 1'b0;
	endtask

	task automatic set_reg(logic [sds_pkg::CFG_IDX_W-1:0] idx,
		logic [sds_pkg::CFG_DATA_W-1:0] value);
		if (idx == sds_pkg::REG_CYL_COUNT)
			cur_count = value;
		if (idx == sds_pkg::REG_HEAD_START)
			cur_head = value[11:0];
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold until every predicted result has drained, then let the block settle.
	task automatic wait_idle();
		while (board.pending_serves.size() != 0)
			@(negedge clk);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic rand_setup();
		int r;
		if ($urandom_range(99) < 70) begin
			r = $urandom_range(99);
			if (r < 15)
				set_reg(sds_pkg::REG_CYL_COUNT, 13'd4096);
			else if (r < 25)
				set_reg(sds_pkg::REG_CYL_COUNT, 13'($urandom_range(8191, 0)));
			else if (r < 35)
				set_reg(sds_pkg::REG_CYL_COUNT, 13'd2);
			else
				set_reg(sds_pkg::REG_CYL_COUNT, 13'($urandom_range(300, 2)));
		end
		if ($urandom_range(99) < 70) begin
			r = $urandom_range(99);
			if (r < 15)
				set_reg(sds_pkg::REG_HEAD_START, 13'd0);
			else if (r < 25)
				set_reg(sds_pkg::REG_HEAD_START, 13'd4095);
			else
				set_reg(sds_pkg::REG_HEAD_START, 13'($urandom_range(top_edge(), 0)));
		end
		if ($urandom_range(99) < 70)
			set_reg(sds_pkg::REG_DIRECTION_UP, 13'($urandom_range(1, 0)));
	endtask

	function automatic bit [11:0] pick_cyl();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return 12'd4095;
		else if (r < 18)
			return cur_head > top_edge() ? top_edge() : cur_head;
		else if (r < 25)
			return 12'd0;
		else if (r < 32)
			return top_edge();
		else if (r < 40)
			return 12'($urandom_range(4095, 0));
		return 12'($urandom_range(top_edge(), 0));
	endfunction

	task automatic run_batch(int size);
		batch_q.delete();
		repeat (size) batch_q.push_back(pick_cyl());
		send_queued();
	endtask

	initial begin
		int b;
		int size;
		board = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		batch_q = '{12'd0, 12'd4095, 12'd50, 12'd120, 12'd30};
		send_queued();

		wait_idle();
		set_reg(sds_pkg::REG_CYL_COUNT, 13'd4096);
		set_reg(sds_pkg::REG_HEAD_START, 13'd4095);
		set_reg(sds_pkg::REG_DIRECTION_UP, 13'd0);
		batch_q = '{12'd4095, 12'd0, 12'd2048};
		send_queued();

		wait_idle();
		set_reg(sds_pkg::REG_CYL_COUNT, 13'd0);
		set_reg(sds_pkg::REG_DIRECTION_UP, 13'd1);
		batch_q = '{12'd1, 12'd3000};
		send_queued();

		wait_idle();
		set_reg(sds_pkg::REG_CYL_COUNT, 13'd8191);
		batch_q = '{12'd10, 12'd100};
		send_queued();

		wait_idle();
		set_reg(sds_pkg::REG_CYL_COUNT, 13'd1000);
		set_reg(sds_pkg::REG_HEAD_START, 13'd0);
		set_reg(sds_pkg::REG_DIRECTION_UP, 13'd0);
		batch_q = '{12'd500};
		send_queued();

		wait_idle();
		set_reg(sds_pkg::REG_CYL_COUNT, 13'd4096);
		set_reg(sds_pkg::REG_HEAD_START, 13'd2048);
		batch_q = '{12'h555, 12'haaa, 12'd2048};
		send_queued();

		b = 0;
		while (sent < NUM_ITEMS) begin
			wait_idle();
			rand_setup();
			calm = (b >= 3 && b < 6);
			if (b == 2)
				size = 32;
			else if (b == 4)
				size = $urandom_range(35, 33);
			else
				size = $urandom_range(8, 1);
			run_batch(size);
			b++;
		end
		calm = 1'b0;
		wait_idle();

		if (board.errors == 0 && board.pending_serves.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
hw/rtl/sds_pkg.sv
hw/rtl/sds_datapath.sv
hw/rtl/sds_ctrl.sv
hw/rtl/scan_disk_scheduler.sv
hw/rtl/sds_checker.sv
dv/tb_scan_disk_scheduler.sv
